// ----- sv/filtered_zero_cross_period_trigger_defines.svh -----
// Assertion helpers for the trigger block; they sample on clk and stand down during arst_n.
`ifndef FILTERED_ZERO_CROSS_PERIOD_TRIGGER_DEFINES_SVH
`define FILTERED_ZERO_CROSS_PERIOD_TRIGGER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset.
`define FZCPT_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Check that an effect holds in the cycle after its cause.
`define FZCPT_ASSERT_NEXT(lbl, cause, effect, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);
`else
`define FZCPT_ASSERT_ALWAYS(lbl, cond, msg)
`define FZCPT_ASSERT_NEXT(lbl, cause, effect, msg)
`endif

`endif

// ----- sv/fzcpt_pkg.sv -----
package fzcpt_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_B0          = 3'd0,
		REG_COEF_A1          = 3'd1,
		REG_COEF_A2          = 3'd2,
		REG_WINDOW_SAMPLES   = 3'd3,
		REG_MIN_PERIOD       = 3'd4,
		REG_TARGET_CROSSINGS = 3'd5,
		REG_HOLDOFF_GAP      = 3'd6
	} cfg_reg_t;

	// register widths
	localparam int COEF_REG_W = 24;
	localparam int WINDOW_W   = 16;
	localparam int MINPER_W   = 16;
	localparam int TARGET_W   = 4;
	localparam int HOLDOFF_W  = 10;

	// register reset values
	localparam logic [WINDOW_W-1:0]  WINDOW_RST  = 16'd2000;
	localparam logic [MINPER_W-1:0]  MINPER_RST  = 16'd400;
	localparam logic [TARGET_W-1:0]  TARGET_RST  = 4'd3;
	localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST = 10'd100;

	// crossing counter saturates here
	localparam logic [TARGET_W-1:0] CROSS_MAX = 4'd15;

	// result fields
	localparam int PERIOD_W   = 16;
	localparam int EDGE_W     = 16;
	localparam int OUT_DATA_W = PERIOD_W + EDGE_W;

endpackage

// ----- sv/filtered_zero_cross_period_trigger.sv -----
// Channel    | Beat                                      | Handshake
// s_axis     | tdata: peak_min, peak_max; tuser: start   | tvalid / tready
// m_axis     | tdata: period_length, first_edge_index;   | tvalid / tready
//            | tuser: target_reached                     |
// cfg        | cfg_idx selects register, cfg_data value  | cfg_wen, no wait
//
// One beat per clock while no result is held on m_axis: an input beat lands
// in the stage-1 register and is processed when stage 1 advances, where the
// biquad (three multipliers: the shared b0 path and the two feedback taps)
// and the crossing logic update the state and, at most once per beat, load
// the result register.
// arst_n resets all but the result data; after reset the block idles until
// a start beat. A result waiting on m_axis holds stage 1 only; one more beat
// is still taken while stage 1 is empty.
`include "filtered_zero_cross_period_trigger_defines.svh"

module filtered_zero_cross_period_trigger #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 22,
	parameter int INDEX_WIDTH    = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	// config write port
	input  logic                                        cfg_wen,
	input  logic [fzcpt_pkg::CFG_IDX_W-1:0]             cfg_idx,
	input  logic [fzcpt_pkg::CFG_DATA_W-1:0]            cfg_data,
	// input stream
	input  logic                                        s_axis_tvalid,
	output logic                                        s_axis_tready,
	// peak_min, peak_max, zero padding
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
	// start_req
	input  logic                                        s_axis_tuser,
	// result stream
	output logic                                        m_axis_tvalid,
	input  logic                                        m_axis_tready,
	// period_length, first_edge_index
	output logic [fzcpt_pkg::OUT_DATA_W-1:0]            m_axis_tdata,
	// target_reached
	output logic                                        m_axis_tuser
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int IW   = INDEX_WIDTH;
	localparam int CF   = COEF_FRAC_BITS;
	localparam int CW   = COEF_FRAC_BITS + 2;   // coefficient width
	localparam int FW   = SAMPLE_WIDTH + 8;     // filter output width
	localparam int XW   = SAMPLE_WIDTH + 2;     // x + 2*x1 + x2
	localparam int FFW  = CW + XW;
	localparam int FBW  = CW + FW;
	localparam int AW   = CW + FW + 2;          // accumulator
	localparam int GW   = IW + fzcpt_pkg::HOLDOFF_W;
	localparam int PW   = IW + fzcpt_pkg::MINPER_W;
	localparam int WW   = IW + fzcpt_pkg::WINDOW_W + 1;
	localparam int EW   = IW + fzcpt_pkg::EDGE_W;

	localparam logic [IW-1:0] IDX_MAX = {IW{1'b1}};
	localparam logic signed [AW-1:0] Y_MAX = {{(AW-FW+1){1'b0}}, {(FW-1){1'b1}}};
	localparam logic signed [AW-1:0] Y_MIN = {{(AW-FW+1){1'b1}}, {(FW-1){1'b0}}};
	localparam logic signed [AW-1:0] RND   = AW'(1) <<< (CF - 1);

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [fzcpt_pkg::COEF_REG_W-1:0] coef_b0_q, coef_a1_q, coef_a2_q;
	logic [fzcpt_pkg::WINDOW_W-1:0]   window_q;
	logic [fzcpt_pkg::MINPER_W-1:0]   min_period_q;
	logic [fzcpt_pkg::TARGET_W-1:0]   target_q;
	logic [fzcpt_pkg::HOLDOFF_W-1:0]  holdoff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0_q    <= '0;
			coef_a1_q    <= '0;
			coef_a2_q    <= '0;
			window_q     <= fzcpt_pkg::WINDOW_RST;
			min_period_q <= fzcpt_pkg::MINPER_RST;
			target_q     <= fzcpt_pkg::TARGET_RST;
			holdoff_q    <= fzcpt_pkg::HOLDOFF_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				fzcpt_pkg::REG_COEF_B0:          coef_b0_q    <= cfg_data;
				fzcpt_pkg::REG_COEF_A1:          coef_a1_q    <= cfg_data;
				fzcpt_pkg::REG_COEF_A2:          coef_a2_q    <= cfg_data;
				fzcpt_pkg::REG_WINDOW_SAMPLES:   window_q     <= cfg_data[fzcpt_pkg::WINDOW_W-1:0];
				fzcpt_pkg::REG_MIN_PERIOD:       min_period_q <= cfg_data[fzcpt_pkg::MINPER_W-1:0];
				fzcpt_pkg::REG_TARGET_CROSSINGS: target_q     <= cfg_data[fzcpt_pkg::TARGET_W-1:0];
				fzcpt_pkg::REG_HOLDOFF_GAP:      holdoff_q    <= cfg_data[fzcpt_pkg::HOLDOFF_W-1:0];
				default: ;
			endcase
		end
	end

	// Coefficients are held as 24-bit words and read at CW bits: truncate when
	// narrower, zero-fill above bit 23 when wider.
	logic [CW+fzcpt_pkg::COEF_REG_W-1:0] b0_ext, a1_ext, a2_ext;
	logic signed [CW-1:0]                b0, a1, a2;

	assign b0_ext = {{CW{1'b0}}, coef_b0_q};
	assign a1_ext = {{CW{1'b0}}, coef_a1_q};
	assign a2_ext = {{CW{1'b0}}, coef_a2_q};
	assign b0     = signed'(b0_ext[CW-1:0]);
	assign a1     = signed'(a1_ext[CW-1:0]);
	assign a2     = signed'(a2_ext[CW-1:0]);

	// ---------------------------------------------------------------------
	// Stage 1: input register, midpoint formed on the way in
	// ---------------------------------------------------------------------
	logic signed [SW-1:0] in_min, in_max;
	logic signed [SW:0]   in_sum;
	logic                 valid_s1;
	logic                 start_s1;
	logic signed [SW-1:0] mid_s1;
	logic                 advance;

	assign in_min = signed'(s_axis_tdata[SW-1:0]);
	assign in_max = signed'(s_axis_tdata[2*SW-1:SW]);
	assign in_sum = (SW+1)'(in_min) + (SW+1)'(in_max);

	// advance stage 1 only when the result register is free or draining
	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			start_s1 <= 1'b0;
			mid_s1   <= '0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
			if (s_axis_tvalid) begin
				start_s1 <= s_axis_tuser;
				mid_s1   <= in_sum[SW:1];   // floor of the halved sum
			end
		end
	end

	// ---------------------------------------------------------------------
	// Search state
	// ---------------------------------------------------------------------
	logic [IW-1:0]                   idx_q, last_q, first_q;
	logic [fzcpt_pkg::TARGET_W-1:0]  cross_cnt_q;
	logic                            have_q;
	logic                            done_q;
	logic signed [SW-1:0]            x1_q, x2_q;
	logic signed [FW-1:0]            y1_q, y2_q, prev_q;

	// ---------------------------------------------------------------------
	// Biquad: b0*(x + 2*x1 + x2) - a1*y1 - a2*y2, exact, then round half up
	// to drop the 22 coefficient fraction bits (COEF_FRAC_BITS) and saturate
	// ---------------------------------------------------------------------
	logic signed [XW-1:0]  ff_x;
	logic signed [FFW-1:0] ff_p;
	logic signed [FBW-1:0] fb1_p, fb2_p;
	logic signed [AW-1:0]  acc, acc_rnd, y_full;
	logic signed [FW-1:0]  y_new;

	assign ff_x    = XW'(mid_s1) + (XW'(x1_q) <<< 1) + XW'(x2_q);
	assign ff_p    = FFW'(b0) * FFW'(ff_x);
	assign fb1_p   = FBW'(a1) * FBW'(y1_q);
	assign fb2_p   = FBW'(a2) * FBW'(y2_q);
	assign acc     = AW'(ff_p) - AW'(fb1_p) - AW'(fb2_p);
	assign acc_rnd = acc + RND;
	assign y_full  = acc_rnd >>> CF;

	always_comb begin
		if (y_full > Y_MAX) begin
			y_new = Y_MAX[FW-1:0];
		end else if (y_full < Y_MIN) begin
			y_new = Y_MIN[FW-1:0];
		end else begin
			y_new = y_full[FW-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// Crossing detection and result selection
	// ---------------------------------------------------------------------
	logic [IW-1:0]                   idx_new, gap, first_upd, span, edge_idx;
	logic [fzcpt_pkg::TARGET_W-1:0]  cnt_new;
	logic                            down_cross, gap_ok, take, have_new;
	logic                            hit, win_end, short_win, emit;
	logic [PW-1:0]                   span_x, minper_x, period_x;
	logic [EW-1:0]                   edge_x;
	logic [fzcpt_pkg::PERIOD_W-1:0]  res_period;
	logic [fzcpt_pkg::EDGE_W-1:0]    res_edge;
	logic                            res_hit;

	assign idx_new    = (idx_q == IDX_MAX) ? idx_q : idx_q + IW'(1);
	assign down_cross = (y_new <= 0) && (prev_q > 0);
	assign gap        = idx_new - last_q;
	assign gap_ok     = !have_q || (GW'(gap) > GW'(holdoff_q));
	assign take       = down_cross && gap_ok;
	// the first crossing of a search is never held off
	assign first_upd  = have_q ? first_q : idx_new;
	assign have_new   = have_q || take;
	assign cnt_new    = (cross_cnt_q == fzcpt_pkg::CROSS_MAX) ? cross_cnt_q
	                                                          : cross_cnt_q + fzcpt_pkg::TARGET_W'(1);
	assign hit        = take && (cnt_new == target_q);
	assign span       = idx_new - first_upd;
	assign win_end    = (WW'(idx_new) + WW'(1) >= WW'(window_q)) || (idx_new == IDX_MAX);
	assign short_win  = window_q < fzcpt_pkg::WINDOW_W'(2);

	// raise the span to min_period, report the low 16 bits
	assign span_x   = PW'(span);
	assign minper_x = PW'(min_period_q);
	assign period_x = (span_x < minper_x) ? minper_x : span_x;
	assign edge_idx = have_new ? first_upd : '0;
	assign edge_x   = EW'(edge_idx);

	always_comb begin
		priority if (start_s1) begin
			emit       = short_win;
			res_period = '0;
			res_edge   = '0;
			res_hit    = 1'b0;
		end else if (done_q) begin
			emit       = 1'b0;
			res_period = '0;
			res_edge   = '0;
			res_hit    = 1'b0;
		end else if (hit) begin
			emit       = 1'b1;
			res_period = period_x[fzcpt_pkg::PERIOD_W-1:0];
			res_edge   = edge_x[fzcpt_pkg::EDGE_W-1:0];
			res_hit    = 1'b1;
		end else begin
			emit       = win_end;
			res_period = min_period_q;
			res_edge   = edge_x[fzcpt_pkg::EDGE_W-1:0];
			res_hit    = 1'b0;
		end
	end

	// ---------------------------------------------------------------------
	// State update: seed on start, step the filter on every live beat
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			last_q      <= '0;
			first_q     <= '0;
			cross_cnt_q <= '0;
			have_q      <= 1'b0;
			done_q      <= 1'b1;
			x1_q        <= '0;
			x2_q        <= '0;
			y1_q        <= '0;
			y2_q        <= '0;
			prev_q      <= '0;
		end else if (advance) begin
			if (start_s1) begin
				idx_q       <= '0;
				last_q      <= '0;
				first_q     <= '0;
				cross_cnt_q <= '0;
				have_q      <= 1'b0;
				done_q      <= short_win;
				x1_q        <= mid_s1;
				x2_q        <= mid_s1;
				y1_q        <= FW'(mid_s1);
				y2_q        <= FW'(mid_s1);
				prev_q      <= FW'(mid_s1);
			end else if (!done_q) begin
				idx_q  <= idx_new;
				x1_q   <= mid_s1;
				x2_q   <= x1_q;
				y1_q   <= y_new;
				y2_q   <= y1_q;
				prev_q <= y_new;
				if (take) begin
					have_q      <= 1'b1;
					first_q     <= first_upd;
					cross_cnt_q <= cnt_new;
					last_q      <= idx_new;
				end
				if (hit || win_end) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------------
	logic [fzcpt_pkg::PERIOD_W-1:0] out_period_q;
	logic [fzcpt_pkg::EDGE_W-1:0]   out_edge_q;
	logic                           out_hit_q;
	logic                           out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_period_q <= res_period;
			out_edge_q   <= res_edge;
			out_hit_q    <= res_hit;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_edge_q, out_period_q};
	assign m_axis_tuser  = out_hit_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	`FZCPT_ASSERT_ALWAYS(a_no_overwrite, !(advance && m_axis_tvalid && !m_axis_tready),
		"stage 1 advanced over a held result")
	`FZCPT_ASSERT_ALWAYS(a_count_vs_have, (cross_cnt_q != '0) == have_q,
		"crossing count and first-crossing flag disagree")
	`FZCPT_ASSERT_NEXT(a_emit_ends_search, advance && emit, done_q && m_axis_tvalid,
		"search still live after a result")

endmodule
